// ----- rtl/cas_pkg.sv -----
// cas_pkg: shared constants, types and state encodings of the curvature arc segmenter
// no dependencies; used by cas_if, cas_engine and curvature_arc_segmenter
package cas_pkg;

  localparam int COORD_BITS     = 16;
  localparam int INDEX_BITS     = 16;
  localparam int CURV_FRAC_BITS = 16;
  localparam int COORD_FRAC     = 4;
  localparam int CURV_BITS      = 8 + CURV_FRAC_BITS;

  // squared side length and cross product magnitude
  localparam int SIDE_W  = 2 * COORD_BITS + 1;
  localparam int PROD_W  = 3 * SIDE_W;
  localparam int RSQ_W   = 2 * SIDE_W;
  localparam int R_SHIFT = 2 + 2 * COORD_FRAC + 2 * CURV_FRAC_BITS;
  localparam int REM_W   = RSQ_W + R_SHIFT;
  localparam int RAD_W   = 2 * CURV_BITS;
  localparam int DV_W    = PROD_W + RAD_W;
  localparam int QUO_W   = RAD_W + 1;
  localparam int TOTAL_W = CURV_BITS + INDEX_BITS;
  localparam int CNT_W   = $clog2(QUO_W + 1);
  localparam int BIT_W   = $clog2(CURV_BITS);

  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEG   = 1'd1;

  localparam logic [CURV_BITS-1:0]  TOL_RESET    = CURV_BITS'(16384);
  localparam logic [INDEX_BITS-1:0] MAXSEG_RESET = '1;
  localparam logic [INDEX_BITS-1:0] INDEX_MAX    = '1;

  // squaring sequence: eight products, then one evaluation step
  localparam logic [CNT_W-1:0] SQR_LAST = CNT_W'(8);

  typedef enum logic {OP_CURV, OP_MEAN} cas_op_e;

  typedef enum logic [1:0] {JOB_CR, JOB_D12, JOB_PROD} cas_job_e;

  typedef enum logic [2:0] {EN_IDLE, EN_SQR, EN_MUL, EN_DIV, EN_ROOT} cas_eng_state_e;

  typedef enum logic [1:0] {ST_IDLE, ST_CURV, ST_MEAN, ST_COMMIT} cas_state_e;

  typedef struct packed {
    logic                  go;
    cas_op_e               op;
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic [COORD_BITS-1:0] bx;
    logic [COORD_BITS-1:0] by;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [TOTAL_W-1:0]    total;
    logic [INDEX_BITS-1:0] samples;
  } cas_cmd_t;

  typedef struct packed {
    logic                 done;
    logic [CURV_BITS-1:0] result;
  } cas_rsp_t;

endpackage

// ----- rtl/cas_if.sv -----
// cas_if: valid/ready channels for input points and closed segments
// depends on cas_pkg
interface cas_point_if import cas_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  path_start;

  modport source (output valid, output point_x, output point_y, output path_start,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input path_start,
                output ready);
endinterface

interface cas_seg_if import cas_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] start_index;
  logic [INDEX_BITS-1:0] point_count;
  logic [CURV_BITS-1:0]  avg_curvature;

  modport source (output valid, output start_index, output point_count,
                  output avg_curvature, input ready);
  modport sink (input valid, input start_index, input point_count,
                input avg_curvature, output ready);
endinterface

// ----- rtl/cas_engine.sv -----
// cas_engine: iterative arithmetic for three-point curvature and segment mean
// shared shift-add multiplier, restoring divider and bitwise root; depends on cas_pkg
module cas_engine import cas_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cas_cmd_t cmd_i,
  output cas_rsp_t rsp_o
);

  cas_eng_state_e st_q, st_d;
  logic [CNT_W-1:0] step_q, step_d;
  cas_op_e op_q, op_d;
  cas_job_e job_q, job_d;

  logic [COORD_BITS-1:0] ux_q, uy_q, vx_q, vy_q, wx_q, wy_q;
  logic [COORD_BITS-1:0] ux_d, uy_d, vx_d, vy_d, wx_d, wy_d;
  logic sux_q, suy_q, svx_q, svy_q, sux_d, suy_d, svx_d, svy_d;
  logic [SIDE_W-1:0] d1_q, d2_q, d3_q, d1_d, d2_d, d3_d;
  logic [2*COORD_BITS-1:0] p_q, q_q, p_d, q_d;
  logic [PROD_W-1:0] acc_q, acc_d, mc_q, mc_d;
  logic [SIDE_W-1:0] mr_q, mr_d;
  logic [RSQ_W-1:0] rsq_q, rsq_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [DV_W-1:0] dv_q, dv_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [RAD_W-1:0] rad_q, rad_d;
  logic [CURV_BITS-1:0] root_q, root_d, res_q, res_d;
  logic done_q, done_d;

  // per-cycle unit outputs
  logic [COORD_BITS:0] dux, duy, dvx, dvy, dwx, dwy;
  logic [COORD_BITS-1:0] ma, mb;
  logic [2*COORD_BITS-1:0] sq;
  logic [SIDE_W-1:0] cr;
  logic [PROD_W-1:0] acc_n;
  logic ge;
  logic [REM_W-1:0] rem_n;
  logic [QUO_W-1:0] quo_n;
  logic [CURV_BITS-1:0] trial, root_n;
  logic [RAD_W-1:0] tsq;

  assign dux = {1'b0, cmd_i.bx} - {1'b0, cmd_i.ax};
  assign duy = {1'b0, cmd_i.by} - {1'b0, cmd_i.ay};
  assign dvx = {1'b0, cmd_i.cx} - {1'b0, cmd_i.bx};
  assign dvy = {1'b0, cmd_i.cy} - {1'b0, cmd_i.by};
  assign dwx = {1'b0, cmd_i.ax} - {1'b0, cmd_i.cx};
  assign dwy = {1'b0, cmd_i.ay} - {1'b0, cmd_i.cy};

  always_comb begin
    unique case (step_q[2:0])
      3'd0: begin ma = ux_q; mb = ux_q; end
      3'd1: begin ma = uy_q; mb = uy_q; end
      3'd2: begin ma = vx_q; mb = vx_q; end
      3'd3: begin ma = vy_q; mb = vy_q; end
      3'd4: begin ma = wx_q; mb = wx_q; end
      3'd5: begin ma = wy_q; mb = wy_q; end
      3'd6: begin ma = ux_q; mb = vy_q; end
      default: begin ma = uy_q; mb = vx_q; end
    endcase
  end
  assign sq = ma * mb;

  always_comb begin
    if ((sux_q ^ svy_q) != (suy_q ^ svx_q)) begin
      cr = SIDE_W'(p_q) + SIDE_W'(q_q);
    end else if (p_q >= q_q) begin
      cr = SIDE_W'(p_q - q_q);
    end else begin
      cr = SIDE_W'(q_q - p_q);
    end
  end

  assign acc_n = mr_q[0] ? acc_q + mc_q : acc_q;

  assign ge    = {{(DV_W-REM_W){1'b0}}, rem_q} >= dv_q;
  assign rem_n = ge ? rem_q - dv_q[REM_W-1:0] : rem_q;
  assign quo_n = {quo_q[QUO_W-2:0], ge};

  assign trial  = root_q | (CURV_BITS'(1) << step_q[BIT_W-1:0]);
  assign tsq    = trial * trial;
  assign root_n = (tsq <= rad_q) ? trial : root_q;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      EN_IDLE: begin
        if (cmd_i.go) st_d = (cmd_i.op == OP_CURV) ? EN_SQR : EN_DIV;
      end
      EN_SQR: begin
        if (step_q == SQR_LAST) begin
          st_d = (d1_q == '0 || d2_q == '0 || d3_q == '0) ? EN_IDLE : EN_MUL;
        end
      end
      EN_MUL: begin
        if (step_q == '0 && job_q == JOB_PROD) st_d = EN_DIV;
      end
      EN_DIV: begin
        if (step_q == '0) st_d = (op_q == OP_CURV) ? EN_ROOT : EN_IDLE;
      end
      EN_ROOT: begin
        if (step_q == '0) st_d = EN_IDLE;
      end
      default: st_d = EN_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    step_d = step_q; op_d = op_q; job_d = job_q;
    ux_d = ux_q; uy_d = uy_q; vx_d = vx_q; vy_d = vy_q; wx_d = wx_q; wy_d = wy_q;
    sux_d = sux_q; suy_d = suy_q; svx_d = svx_q; svy_d = svy_q;
    d1_d = d1_q; d2_d = d2_q; d3_d = d3_q; p_d = p_q; q_d = q_q;
    acc_d = acc_q; mc_d = mc_q; mr_d = mr_q; rsq_d = rsq_q;
    rem_d = rem_q; dv_d = dv_q; quo_d = quo_q; rad_d = rad_q; root_d = root_q;
    res_d = res_q; done_d = 1'b0;
    unique case (st_q)
      EN_IDLE: begin
        if (cmd_i.go) begin
          op_d = cmd_i.op;
          if (cmd_i.op == OP_CURV) begin
            sux_d = dux[COORD_BITS]; suy_d = duy[COORD_BITS];
            svx_d = dvx[COORD_BITS]; svy_d = dvy[COORD_BITS];
            ux_d = dux[COORD_BITS] ? COORD_BITS'(-dux) : dux[COORD_BITS-1:0];
            uy_d = duy[COORD_BITS] ? COORD_BITS'(-duy) : duy[COORD_BITS-1:0];
            vx_d = dvx[COORD_BITS] ? COORD_BITS'(-dvx) : dvx[COORD_BITS-1:0];
            vy_d = dvy[COORD_BITS] ? COORD_BITS'(-dvy) : dvy[COORD_BITS-1:0];
            wx_d = dwx[COORD_BITS] ? COORD_BITS'(-dwx) : dwx[COORD_BITS-1:0];
            wy_d = dwy[COORD_BITS] ? COORD_BITS'(-dwy) : dwy[COORD_BITS-1:0];
            step_d = '0;
          end else begin
            rem_d  = REM_W'(cmd_i.total);
            dv_d   = DV_W'({cmd_i.samples, {CURV_BITS{1'b0}}});
            quo_d  = '0;
            step_d = CNT_W'(CURV_BITS);
          end
        end
      end
      EN_SQR: begin
        // the evaluation step leaves the squared sides untouched
        if (step_q != SQR_LAST) begin
          unique case (step_q[2:0])
            3'd0: d1_d = SIDE_W'(sq);
            3'd1: d1_d = d1_q + SIDE_W'(sq);
            3'd2: d2_d = SIDE_W'(sq);
            3'd3: d2_d = d2_q + SIDE_W'(sq);
            3'd4: d3_d = SIDE_W'(sq);
            3'd5: d3_d = d3_q + SIDE_W'(sq);
            3'd6: p_d = sq;
            default: q_d = sq;
          endcase
        end
        step_d = step_q + CNT_W'(1);
        if (step_q == SQR_LAST) begin
          if (d1_q == '0 || d2_q == '0 || d3_q == '0) begin
            // degenerate triangle
            res_d  = '0;
            done_d = 1'b1;
          end else begin
            mc_d   = PROD_W'(cr);
            mr_d   = cr;
            acc_d  = '0;
            job_d  = JOB_CR;
            step_d = CNT_W'(SIDE_W - 1);
          end
        end
      end
      EN_MUL: begin
        acc_d  = acc_n;
        mc_d   = mc_q << 1;
        mr_d   = mr_q >> 1;
        step_d = step_q - CNT_W'(1);
        if (step_q == '0) begin
          step_d = CNT_W'(SIDE_W - 1);
          acc_d  = '0;
          unique case (job_q)
            JOB_CR: begin
              rsq_d = acc_n[RSQ_W-1:0];
              mc_d  = PROD_W'(d1_q);
              mr_d  = d2_q;
              job_d = JOB_D12;
            end
            JOB_D12: begin
              mc_d  = acc_n;
              mr_d  = d3_q;
              job_d = JOB_PROD;
            end
            default: begin
              rem_d  = {rsq_q, {R_SHIFT{1'b0}}};
              dv_d   = {acc_n, {RAD_W{1'b0}}};
              quo_d  = '0;
              step_d = CNT_W'(QUO_W - 1);
            end
          endcase
        end
      end
      EN_DIV: begin
        rem_d  = rem_n;
        quo_d  = quo_n;
        dv_d   = dv_q >> 1;
        step_d = step_q - CNT_W'(1);
        if (step_q == '0) begin
          if (op_q == OP_CURV) begin
            // quotient past the radicand range saturates the curvature
            rad_d  = quo_n[QUO_W-1] ? '1 : quo_n[RAD_W-1:0];
            root_d = '0;
            step_d = CNT_W'(CURV_BITS - 1);
          end else begin
            res_d  = quo_n[CURV_BITS-1:0];
            done_d = 1'b1;
          end
        end
      end
      EN_ROOT: begin
        root_d = root_n;
        step_d = step_q - CNT_W'(1);
        if (step_q == '0) begin
          res_d  = root_n;
          done_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= EN_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d; op_q <= op_d; job_q <= job_d;
    ux_q <= ux_d; uy_q <= uy_d; vx_q <= vx_d; vy_q <= vy_d; wx_q <= wx_d; wy_q <= wy_d;
    sux_q <= sux_d; suy_q <= suy_d; svx_q <= svx_d; svy_q <= svy_d;
    d1_q <= d1_d; d2_q <= d2_d; d3_q <= d3_d; p_q <= p_d; q_q <= q_d;
    acc_q <= acc_d; mc_q <= mc_d; mr_q <= mr_d; rsq_q <= rsq_d;
    rem_q <= rem_d; dv_q <= dv_d; quo_q <= quo_d; rad_q <= rad_d; root_q <= root_d;
    res_q <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

// ----- rtl/curvature_arc_segmenter.sv -----
// curvature_arc_segmenter: splits polylines into arcs of steady three-point curvature
// depends on cas_pkg, cas_if and cas_engine
//
// Points arrive one per transfer; the first two points of a path are only stored.
// From the third point on, the curvature is found by one shared arithmetic engine:
// eight 16x16 products and a check, three 33-step shift-add multiplies, a 49-step
// restoring division and a 24-step bitwise square root; when two of the three points
// coincide, the check ends the work after the products and the curvature is zero.
// A point that closes a reported segment adds a 25-step division for the mean. The
// input is not ready while the engine works; a finished segment waits in the output
// register and only holds the block if the next one is due first.
module curvature_arc_segmenter import cas_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  cas_point_if.sink            point_i,
  cas_seg_if.source            seg_o
);

  cas_state_e st_q, st_d;
  cas_cmd_t cmd;
  cas_rsp_t rsp;

  logic [CURV_BITS-1:0] tol_q;
  logic [INDEX_BITS-1:0] maxseg_q;
  logic [COORD_BITS-1:0] older_x_q, older_y_q, newer_x_q, newer_y_q;
  logic [COORD_BITS-1:0] older_x_d, older_y_d, newer_x_d, newer_y_d;
  logic [INDEX_BITS-1:0] ps_q, ps_d, segb_q, segb_d, samples_q, samples_d;
  logic [INDEX_BITS-1:0] emitted_q, emitted_d, mid_q, mid_d;
  logic [CURV_BITS-1:0] prev_q, prev_d, k_q, k_d, mean_q, mean_d;
  logic cv_q, cv_d, emit_q, emit_d, brk_q, brk_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic out_valid_q, out_valid_d;
  logic [INDEX_BITS-1:0] out_start_q, out_count_q, out_start_d, out_count_d;
  logic [CURV_BITS-1:0] out_avg_q, out_avg_d;

  logic accept, new_path, commit, out_busy;
  logic [INDEX_BITS-1:0] eff_ps, seg_len;
  logic [CURV_BITS-1:0] diff, k_now;
  logic brk_now, emit_now;

  assign accept   = point_i.valid && point_i.ready;
  assign new_path = point_i.path_start;
  assign eff_ps   = new_path ? '0 : ps_q;
  assign out_busy = out_valid_q && !seg_o.ready;
  assign commit   = (st_q == ST_COMMIT) && !(emit_q && out_busy);

  // break test on the fresh curvature from the engine
  assign k_now    = rsp.result;
  assign diff     = (k_now > prev_q) ? k_now - prev_q : prev_q - k_now;
  assign seg_len  = mid_q - segb_q;
  assign brk_now  = cv_q && (diff > tol_q);
  assign emit_now = brk_now && (seg_len > INDEX_BITS'(2)) && (emitted_q < maxseg_q)
                    && (emitted_q != INDEX_MAX);

  cas_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rsp_o  (rsp)
  );

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (accept && eff_ps >= INDEX_BITS'(2)) st_d = ST_CURV;
      end
      ST_CURV: begin
        if (rsp.done) st_d = emit_now ? ST_MEAN : ST_COMMIT;
      end
      ST_MEAN: begin
        if (rsp.done) st_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // outputs and engine commands
  always_comb begin
    point_i.ready = (st_q == ST_IDLE);
    cmd.go      = 1'b0;
    cmd.op      = OP_CURV;
    cmd.ax      = older_x_q;
    cmd.ay      = older_y_q;
    cmd.bx      = newer_x_q;
    cmd.by      = newer_y_q;
    cmd.cx      = point_i.point_x;
    cmd.cy      = point_i.point_y;
    cmd.total   = total_q;
    cmd.samples = samples_q;
    unique case (st_q)
      ST_IDLE: cmd.go = accept && (eff_ps >= INDEX_BITS'(2));
      ST_CURV: begin
        cmd.go = rsp.done && emit_now;
        cmd.op = OP_MEAN;
      end
      default: ;
    endcase
  end

  // per-path state
  always_comb begin
    older_x_d = older_x_q; older_y_d = older_y_q;
    newer_x_d = newer_x_q; newer_y_d = newer_y_q;
    ps_d = ps_q; segb_d = segb_q; samples_d = samples_q; emitted_d = emitted_q;
    mid_d = mid_q; prev_d = prev_q; k_d = k_q; mean_d = mean_q;
    cv_d = cv_q; emit_d = emit_q; brk_d = brk_q; total_d = total_q;
    if (accept) begin
      if (new_path) begin
        segb_d = '0; prev_d = '0; cv_d = 1'b0;
        total_d = '0; samples_d = '0; emitted_d = '0;
      end
      older_x_d = new_path ? '0 : newer_x_q;
      older_y_d = new_path ? '0 : newer_y_q;
      newer_x_d = point_i.point_x;
      newer_y_d = point_i.point_y;
      ps_d  = (eff_ps == INDEX_MAX) ? eff_ps : eff_ps + INDEX_BITS'(1);
      mid_d = eff_ps - INDEX_BITS'(1);
    end
    if (st_q == ST_CURV && rsp.done) begin
      k_d = k_now; brk_d = brk_now; emit_d = emit_now;
    end
    if (st_q == ST_MEAN && rsp.done) mean_d = rsp.result;
    if (commit) begin
      if (!cv_q) begin
        cv_d = 1'b1; total_d = TOTAL_W'(k_q); samples_d = INDEX_BITS'(1);
      end else if (brk_q) begin
        segb_d = mid_q; total_d = TOTAL_W'(k_q); samples_d = INDEX_BITS'(1);
        if (emit_q) emitted_d = emitted_q + INDEX_BITS'(1);
      end else if (samples_q != INDEX_MAX) begin
        total_d = total_q + TOTAL_W'(k_q);
        samples_d = samples_q + INDEX_BITS'(1);
      end
      prev_d = k_q;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q && !seg_o.ready;
    out_start_d = out_start_q;
    out_count_d = out_count_q;
    out_avg_d   = out_avg_q;
    if (commit && emit_q) begin
      out_valid_d = 1'b1;
      out_start_d = segb_q;
      out_count_d = seg_len;
      out_avg_d   = mean_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      tol_q <= TOL_RESET; maxseg_q <= MAXSEG_RESET;
      older_x_q <= '0; older_y_q <= '0; newer_x_q <= '0; newer_y_q <= '0;
      ps_q <= '0; segb_q <= '0; samples_q <= '0; emitted_q <= '0;
      prev_q <= '0; cv_q <= 1'b0; total_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TOLERANCE: tol_q <= cfg_data_i[CURV_BITS-1:0];
          CFG_MAX_SEG: maxseg_q <= cfg_data_i[INDEX_BITS-1:0];
          default: ;
        endcase
      end
      older_x_q <= older_x_d; older_y_q <= older_y_d;
      newer_x_q <= newer_x_d; newer_y_q <= newer_y_d;
      ps_q <= ps_d; segb_q <= segb_d; samples_q <= samples_d; emitted_q <= emitted_d;
      prev_q <= prev_d; cv_q <= cv_d; total_q <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_q <= mid_d; k_q <= k_d; mean_q <= mean_d; emit_q <= emit_d; brk_q <= brk_d;
    out_start_q <= out_start_d; out_count_q <= out_count_d; out_avg_q <= out_avg_d;
  end

  assign seg_o.valid         = out_valid_q;
  assign seg_o.start_index   = out_start_q;
  assign seg_o.point_count   = out_count_q;
  assign seg_o.avg_curvature = out_avg_q;

endmodule
